@@ sv/dvd_pkg.sv @@
package dvd_pkg;

  // Width of the running offset and of each decoded delta (8..64).
  localparam int unsigned VALUE_WIDTH = 64;

  // Field widths fixed by the stream format.
  localparam int unsigned OFFSET_W = 64;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned GROUP_W  = 4;

  // Last group index that may still carry the continuation bit is one below this.
  localparam int unsigned GROUP_LAST = (VALUE_WIDTH - 1) / 7;
  localparam int unsigned SHIFT_W    = $clog2(7 * GROUP_LAST + 1);

  localparam logic [7:0] PAYLOAD_MASK = 8'h7f;
  localparam logic [7:0] CONT_MASK    = 8'h80;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_TOO_LONG  = 2'd1,
    ERR_TRUNCATED = 2'd2
  } err_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_list;
    logic       end_of_data;
  } in_item_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] offset_value;
    logic                is_last;
    logic [1:0]          error_code;
  } out_item_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] partial_delta;
    logic [GROUP_W-1:0]     group_index;
    logic [VALUE_WIDTH-1:0] running_offset;
    logic [COUNT_W-1:0]     values_done;
    logic                   list_finished;
    logic                   error_seen;
  } dec_state_t;

endpackage

@@ sv/dvd_step.sv @@
module dvd_step (
  input  dvd_pkg::dec_state_t           state_i,
  input  dvd_pkg::in_item_t             item_i,
  input  logic [dvd_pkg::COUNT_W-1:0]   value_count_i,
  output dvd_pkg::dec_state_t           state_o,
  output logic                          emit_o,
  output dvd_pkg::out_item_t            result_o
);

  dvd_pkg::dec_state_t         cur;
  logic                        active;
  logic [dvd_pkg::GROUP_W-1:0] grp;
  logic [dvd_pkg::SHIFT_W-1:0] shamt;
  logic [dvd_pkg::VALUE_WIDTH-1:0] partial;
  logic [dvd_pkg::VALUE_WIDTH-1:0] offset_sum;
  logic [dvd_pkg::COUNT_W-1:0]     done_inc;
  logic                        cont;
  logic                        too_long;
  logic                        last;

  always_comb begin
    // Start of list clears everything before the byte is used.
    cur = state_i;
    if (item_i.start_of_list) begin
      cur = '0;
    end

    active = !cur.error_seen && !cur.list_finished && (cur.values_done < value_count_i);

    if (cur.group_index > dvd_pkg::GROUP_W'(dvd_pkg::GROUP_LAST)) begin
      grp = dvd_pkg::GROUP_W'(dvd_pkg::GROUP_LAST);
    end else begin
      grp = cur.group_index;
    end
    shamt = dvd_pkg::SHIFT_W'(7 * grp);

    // Group bits above the value width fall off the top of the shift.
    partial = cur.partial_delta |
              (dvd_pkg::VALUE_WIDTH'(item_i.data_byte & dvd_pkg::PAYLOAD_MASK) << shamt);
    offset_sum = cur.running_offset + partial;
    done_inc   = cur.values_done + dvd_pkg::COUNT_W'(1);
    cont       = (item_i.data_byte & dvd_pkg::CONT_MASK) != 8'h00;
    too_long   = grp >= dvd_pkg::GROUP_W'(dvd_pkg::GROUP_LAST);
    last       = done_inc == value_count_i;

    state_o  = cur;
    emit_o   = 1'b0;
    result_o = '0;

    if (active) begin
      if (!cont) begin
        state_o.running_offset = offset_sum;
        state_o.partial_delta  = '0;
        state_o.group_index    = '0;
        state_o.values_done    = done_inc;
        emit_o = 1'b1;
        result_o.offset_value = dvd_pkg::OFFSET_W'(offset_sum);
        if (last) begin
          state_o.list_finished = 1'b1;
          result_o.is_last      = 1'b1;
        end else if (item_i.end_of_data) begin
          state_o.error_seen  = 1'b1;
          result_o.error_code = dvd_pkg::ERR_TRUNCATED;
        end
      end else if (too_long) begin
        state_o.partial_delta = partial;
        state_o.error_seen    = 1'b1;
        emit_o = 1'b1;
        result_o.error_code = dvd_pkg::ERR_TOO_LONG;
      end else begin
        state_o.partial_delta = partial;
        state_o.group_index   = grp + dvd_pkg::GROUP_W'(1);
        if (item_i.end_of_data) begin
          state_o.error_seen  = 1'b1;
          emit_o = 1'b1;
          result_o.error_code = dvd_pkg::ERR_TRUNCATED;
        end
      end
    end
  end

endmodule

@@ sv/delta_varint_decoder_unit.sv @@
// Delta LEB128 varint decoder. Bytes of the varint stream arrive one per
// transfer on the input channel; every completed varint is added (mod 2^64)
// to a running offset and the new offset leaves on the output channel, with
// is_last set on the value_count-th offset. Overlong varints (continuation
// bit still set on the tenth byte) and data that ends early give one result
// carrying an error code, after which the list stays dead until a byte with
// start_of_list. Rate: one byte per clock while the result register is not
// stalled, with no bubbles. A byte passes through the input register, then
// its result goes to the result register; the decode, shift-in and 64-bit
// add sit in one combinational step between those two registers.
// value_count is written through cfg_we_i / cfg_wdata_i and should only
// change while the unit is idle.
module delta_varint_decoder_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [dvd_pkg::COUNT_W-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  dvd_pkg::in_item_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output dvd_pkg::out_item_t          out_data_o
);

  logic [dvd_pkg::COUNT_W-1:0] value_count_q;

  // Input register stage
  logic              in_valid_q;
  dvd_pkg::in_item_t in_item_q;

  // Decoder state and result register
  dvd_pkg::dec_state_t state_q, state_d;
  logic                out_valid_q;
  dvd_pkg::out_item_t  out_item_q;
  dvd_pkg::out_item_t  step_result;
  logic                step_emit;
  logic                advance;

  // The held byte moves on whenever the result register is free or draining,
  // even if the byte itself produces no result.
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;

  dvd_step u_step (
    .state_i       (state_q),
    .item_i        (in_item_q),
    .value_count_i (value_count_q),
    .state_o       (state_d),
    .emit_o        (step_emit),
    .result_o      (step_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_count_q <= '0;
    end else if (cfg_we_i) begin
      value_count_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_item_q <= in_data_i;
    end
  end

  // Decoder state commits when the held byte is consumed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_valid_q && advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q && step_emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q && step_emit) begin
      out_item_q <= step_result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

// Stream-level test of the delta varint decoder: bytes are pushed through the
// input channel, every transfer is run through a behavioral decoder kept in
// the scoreboard, and each result transfer is checked against the oldest
// predicted offset.
module tb_top;
  import dvd_pkg::*;

  // Highest group index the decoder ever shifts by (tenth byte).
  localparam int unsigned MAX_GROUP    = 9;
  // Two register stages inside the unit; a few spare cycles on top.
  localparam int unsigned DRAIN_CYCLES = 8;
  // Byte transfers before the random part stops.
  localparam int unsigned TARGET_BYTES = 1350;
  localparam int unsigned REPORT_LIMIT = 10;

  // Receiver back-pressure patterns.
  typedef enum int unsigned {
    RX_OPEN,
    RX_COIN,
    RX_COMB,
    RX_SPARSE
  } rx_mode_e;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [COUNT_W-1:0] cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  in_item_t           in_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  out_item_t          out_data_o;

  delta_varint_decoder_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Scoreboard: holds its own copy of the decoder state and the count
  // register, predicts the offset (if any) each byte produces, and matches
  // result transfers against those predictions in order.
  class offset_scoreboard;
    logic [COUNT_W-1:0]     value_count;
    logic [VALUE_WIDTH-1:0] partial_delta;
    logic [VALUE_WIDTH-1:0] running_offset;
    logic [GROUP_W-1:0]     group_idx;
    logic [COUNT_W-1:0]     values_done;
    bit                     list_done;
    bit                     err_sticky;
    out_item_t              expected_offsets[$];
    int unsigned            mismatches;
    int unsigned            bytes_seen;

    function new();
      value_count = '0;
      mismatches  = 0;
      bytes_seen  = 0;
      clear_list();
    endfunction

    function void clear_list();
      partial_delta  = '0;
      running_offset = '0;
      group_idx      = '0;
      values_done    = '0;
      list_done      = 1'b0;
      err_sticky     = 1'b0;
    endfunction

    function void set_count(logic [COUNT_W-1:0] v);
      value_count = v;
    endfunction

    function int unsigned pending();
      return expected_offsets.size();
    endfunction

    function void add_expected(out_item_t r);
      expected_offsets.insert(expected_offsets.size(), r);
    endfunction

    // Decode one accepted byte and queue the offset it produces, if any.
    function void note_byte(in_item_t it);
      out_item_t              res;
      logic [VALUE_WIDTH-1:0] shifted;
      logic [7:0]             payload;
      int unsigned            g;
      bytes_seen++;
      if (it.start_of_list) clear_list();
      // Dead list: sticky error, finished, or count already reached.
      if (err_sticky || list_done || values_done >= value_count) return;
      g = group_idx;
      if (g > MAX_GROUP) g = MAX_GROUP;
      payload = it.data_byte & PAYLOAD_MASK;
      shifted = {{(VALUE_WIDTH-7){1'b0}}, payload[6:0]};
      shifted = shifted << (7 * g);   // bits past the top simply fall off
      partial_delta = partial_delta | shifted;
      res = '0;
      if (!(|(it.data_byte & CONT_MASK))) begin
        running_offset = running_offset + partial_delta;
        partial_delta  = '0;
        group_idx      = '0;
        values_done    = values_done + 1'b1;
        res.offset_value = OFFSET_W'(running_offset);
        if (values_done == value_count) begin
          list_done   = 1'b1;
          res.is_last = 1'b1;
          res.error_code = ERR_NONE;
        end else if (it.end_of_data) begin
          err_sticky = 1'b1;
          res.error_code = ERR_TRUNCATED;
        end else begin
          res.error_code = ERR_NONE;
        end
        add_expected(res);
        return;
      end
      // Continuation on the last group: overlong wins over truncation.
      if (7 * (g + 1) >= VALUE_WIDTH) begin
        err_sticky = 1'b1;
        res.error_code = ERR_TOO_LONG;
        add_expected(res);
        return;
      end
      group_idx = GROUP_W'(g + 1);
      if (it.end_of_data) begin
        err_sticky = 1'b1;
        res.error_code = ERR_TRUNCATED;
        add_expected(res);
      end
    endfunction

    function void check_offset(out_item_t got);
      out_item_t want;
      if (expected_offsets.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: offset=%h last=%b err=%0d",
                   got.offset_value, got.is_last, got.error_code);
        return;
      end
      want = expected_offsets.pop_front();
      if (got.offset_value !== want.offset_value || got.is_last !== want.is_last ||
          got.error_code !== want.error_code) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("mismatch: exp off=%h last=%b err=%0d, got off=%h last=%b err=%0d",
                   want.offset_value, want.is_last, want.error_code,
                   got.offset_value, got.is_last, got.error_code);
      end
    endfunction
  endclass

  offset_scoreboard offsets;
  int unsigned      burst_left = 0;

  // 8 ns clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Both channels are sampled at the rising edge; stimulus moves on the
  // falling edge, so everything seen here is settled.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) offsets.note_byte(in_data_i);
      if (out_valid_o && out_ready_i) offsets.check_offset(out_data_o);
    end
  end

  // Receiver: switches between back-pressure patterns at random intervals,
  // including stretches where it never stalls.
  initial begin
    rx_mode_e    mode;
    int unsigned span;
    int unsigned tick;
    out_ready_i = 1'b0;
    tick = 0;
    forever begin
      mode = rx_mode_e'($urandom_range(0, 3));
      span = $urandom_range(30, 250);
      repeat (span) begin
        @(negedge clk_i);
        tick++;
        case (mode)
          RX_OPEN: out_ready_i <= 1'b1;
          RX_COIN: out_ready_i <= 1'($urandom_range(0, 1));
          RX_COMB: out_ready_i <= ((tick % 9) < 5);
          default: out_ready_i <= ($urandom_range(0, 15) != 0);
        endcase
      end
    end
  end

  function automatic in_item_t mk(logic [7:0] b, logic sol, logic eod);
    in_item_t it;
    it.data_byte     = b;
    it.start_of_list = sol;
    it.end_of_data   = eod;
    return it;
  endfunction

  // One transfer. The sender runs in bursts; between bursts valid drops for a
  // random number of cycles (sometimes none, so bursts run back to back).
  task automatic send_byte(in_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
      repeat (gap) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Stop sending and let every predicted result come out, then give the
  // pipeline time to swallow bytes that produce nothing.
  task automatic wait_drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (offsets.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Count register is only touched with the unit idle.
  task automatic write_count(logic [COUNT_W-1:0] v);
    wait_drain();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    offsets.set_count(v);
  endtask

  // One random phase: maybe a new count, then mostly a well-formed list
  // (start, N varints, end on the final byte) with occasional truncation,
  // overlong varints, trailing junk and mid-list drains. Phases that keep the
  // count may also skip the start and carry on with the open list, which is
  // how a count at or below the values already done gets exercised.
  task automatic random_phase();
    int unsigned pick;
    int unsigned nvals;
    int unsigned nbytes;
    int unsigned cut;
    int unsigned i;
    int unsigned k;
    bit          first;
    bit          overlong;
    bit          trunc;
    bit          stop;
    bit          eod;
    logic [7:0]  b;
    pick = $urandom_range(0, 99);
    if (pick < 6) write_count('0);
    else if (pick < 12) write_count(COUNT_W'(1));
    else if (pick < 18) write_count('1);
    else if (pick < 24) write_count($urandom());
    else if (pick < 60) write_count(COUNT_W'($urandom_range(2, 8)));

    if ($urandom_range(0, 9) == 0) begin
      // pure noise, any flags
      repeat ($urandom_range(4, 12))
        send_byte(mk(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0,
                     $urandom_range(0, 4) == 0));
      return;
    end

    if (offsets.value_count >= 1 && offsets.value_count <= 8)
      nvals = offsets.value_count;
    else
      nvals = $urandom_range(1, 6);
    pick = $urandom_range(0, 9);
    if (pick == 0) nvals++;
    else if (pick == 1 && nvals > 1) nvals--;

    first = ($urandom_range(0, 6) != 0);
    stop  = 1'b0;
    for (i = 0; i < nvals && !stop; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) nbytes = $urandom_range(1, 2);
      else if (pick < 90) nbytes = $urandom_range(3, 5);
      else nbytes = $urandom_range(6, MAX_GROUP + 1);
      overlong = ($urandom_range(0, 39) == 0);
      if (overlong) nbytes = MAX_GROUP + 1;
      trunc = ($urandom_range(0, 29) == 0);
      cut   = $urandom_range(1, nbytes);
      for (k = 1; k <= nbytes; k++) begin
        b = 8'($urandom_range(0, 255));
        b = (k < nbytes || overlong) ? (b | CONT_MASK) : (b & PAYLOAD_MASK);
        eod = (trunc && k == cut) ||
              (i == nvals - 1 && k == nbytes && $urandom_range(0, 4) != 0);
        send_byte(mk(b, first, eod));
        first = 1'b0;
        if (trunc && k == cut) begin
          stop = 1'b1;
          break;
        end
      end
      if (overlong) stop = 1'b1;
      // occasional full pause mid-stream
      if ($urandom_range(0, 49) == 0) wait_drain();
    end

    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3))
        send_byte(mk(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1))));
  endtask

  initial begin
    offsets     = new();
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    rst_ni      = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: zero delta, widest one-byte delta, then a ten-byte delta of
    // all ones whose top group keeps only bit 63; the sum wraps and is last.
    write_count(COUNT_W'(3));
    send_byte(mk(8'h00, 1'b1, 1'b0));
    send_byte(mk(PAYLOAD_MASK, 1'b0, 1'b0));
    repeat (MAX_GROUP) send_byte(mk(8'hff, 1'b0, 1'b0));
    send_byte(mk(8'h01, 1'b0, 1'b1));

    // Count at its maximum: data ends mid-varint, then a finished value on
    // the final byte, then an overlong varint whose last byte also ends data.
    write_count('1);
    send_byte(mk(8'h01, 1'b1, 1'b0));
    send_byte(mk(8'h82, 1'b0, 1'b1));
    send_byte(mk(8'h03, 1'b1, 1'b1));
    send_byte(mk(CONT_MASK, 1'b1, 1'b0));
    repeat (MAX_GROUP - 1) send_byte(mk(8'hff, 1'b0, 1'b0));
    send_byte(mk(8'hff, 1'b0, 1'b1));

    // Count of zero: the list is never active, end of data is silent.
    write_count('0);
    send_byte(mk(8'h85, 1'b1, 1'b1));

    while (offsets.bytes_seen < TARGET_BYTES) random_phase();

    wait_drain();
    if (offsets.mismatches == 0 && offsets.pending() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Watchdog, far beyond any correct run.
  initial begin
    #5000000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

@@ delta_varint_decoder_unit.f @@
sv/dvd_pkg.sv
sv/dvd_step.sv
sv/delta_varint_decoder_unit.sv
tb/sv/tb_top.sv
